// ===== hdl/tril_pkg.sv =====
`default_nettype none

package tril_pkg;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    typedef struct packed {
        logic       action;
        logic [7:0] symbol;
        logic       last_symbol;
    } in_t;

    typedef struct packed {
        logic found;
        logic table_full;
    } out_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_STEP,
        ST_MARK,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic clear_en;
        logic accept_en;
        logic step_en;
        logic mark_en;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic last;
        logic lookup;
        logic out_free;
    } ctrl_sts_t;

endpackage

`default_nettype wire

// ===== hdl/trie_insert_lookup_unit.sv =====
// channel   ports                          transfer when
// input     s_valid s_ready s_payload      s_valid && s_ready
// result    m_valid m_ready m_payload      m_valid && m_ready
//
// A symbol goes through a child-link memory read, then a walk or allocate.
// Final symbol: insert then loads the result, lookup first adds an end-mark
// memory read; either may wait for the output register to drain.
// After reset a clearing pass over all NODES*ALPHABET link entries (262144 by
// default) zeroes both memories; no input is taken until it ends.
// A waiting result sits in the output register while new symbols are taken.
`default_nettype none

module trie_insert_lookup_unit #(
    parameter int NODES    = 1024,
    parameter int ALPHABET = 256
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire tril_pkg::in_t  s_payload,
    output logic                m_valid,
    input  wire logic           m_ready,
    output tril_pkg::out_t      m_payload
);

    import tril_pkg::*;

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    tril_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .sts     (sts),
        .cmd     (cmd)
    );

    tril_dp #(
        .NODES    (NODES),
        .ALPHABET (ALPHABET)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_payload (s_payload),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

`default_nettype wire

// ===== hdl/tril_ram.sv =====
`default_nettype none

module tril_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== hdl/tril_ctrl.sv =====
`default_nettype none

module tril_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    input  wire tril_pkg::ctrl_sts_t sts,
    output tril_pkg::ctrl_cmd_t      cmd
);

    import tril_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (sts.clear_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP: begin
                if (!sts.last) begin
                    state_next = ST_IDLE;
                end else if (sts.lookup) begin
                    state_next = ST_MARK;
                end else begin
                    state_next = ST_RESULT;
                end
            end
            ST_MARK: begin
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        cmd = '0;
        unique case (state_reg)
            ST_CLEAR:  cmd.clear_en  = 1'b1;
            ST_IDLE:   cmd.accept_en = 1'b1;
            ST_STEP:   cmd.step_en   = 1'b1;
            ST_MARK:   cmd.mark_en   = 1'b1;
            ST_RESULT: cmd.load_out  = sts.out_free;
            default:   cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/tril_dp.sv =====
`default_nettype none

module tril_dp #(
    parameter int NODES    = 1024,
    parameter int ALPHABET = 256
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    input  wire tril_pkg::in_t       s_payload,
    output logic                     s_ready,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output tril_pkg::out_t           m_payload,
    input  wire tril_pkg::ctrl_cmd_t cmd,
    output tril_pkg::ctrl_sts_t      sts
);

    import tril_pkg::*;

    localparam int NODE_W = $clog2(NODES);
    localparam int SYM_W  = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
    localparam int TOTAL  = NODES * ALPHABET;
    localparam int ADDR_W = $clog2(TOTAL);

    localparam logic [NODE_W:0]   NODES_V   = (NODE_W+1)'(NODES);
    localparam logic [NODE_W-1:0] ROOT      = NODE_W'(1);
    localparam logic [ADDR_W-1:0] NODES_A   = ADDR_W'(NODES);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TOTAL - 1);

    // symbol reduced into the alphabet
    logic [SYM_W-1:0] sym_lut [256];
    for (genvar i = 0; i < 256; i++) begin : g_sym_lut
        assign sym_lut[i] = SYM_W'(i % ALPHABET);
    end

    logic [NODE_W-1:0] node_reg, node_next;
    logic [NODE_W-1:0] used_reg, used_next;
    logic              missed_reg, missed_next;
    logic              ran_out_reg, ran_out_next;
    logic              act_reg, act_next;
    logic              last_reg, last_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    out_t              res_reg, res_next;
    logic              m_valid_reg, m_valid_next;
    out_t              m_payload_reg, m_payload_next;

    logic [SYM_W-1:0]  sym_mod;
    logic [ADDR_W-1:0] addr_calc;
    logic              accept;
    logic [NODE_W:0]   used_inc;
    logic              link_ok;
    logic [NODE_W-1:0] node_step;
    logic              missed_step;
    logic              ran_step;

    logic              link_we;
    logic [ADDR_W-1:0] link_waddr;
    logic [NODE_W-1:0] link_wdata;
    logic [NODE_W-1:0] link_rdata;
    logic              mark_we;
    logic [NODE_W-1:0] mark_waddr;
    logic              mark_wdata;
    logic              mark_rdata;

    assign sym_mod   = sym_lut[s_payload.symbol];
    assign addr_calc = ADDR_W'(node_reg) * ADDR_W'(ALPHABET) + ADDR_W'(sym_mod);
    assign accept    = cmd.accept_en & s_valid;
    assign used_inc  = {1'b0, used_reg} + (NODE_W+1)'(1);
    assign link_ok   = (link_rdata != '0) && ({1'b0, link_rdata} < NODES_V);

    assign link_waddr = cmd.clear_en ? clr_cnt_reg : addr_reg;
    assign mark_waddr = cmd.clear_en ? clr_cnt_reg[NODE_W-1:0] : node_step;
    assign mark_wdata = ~cmd.clear_en;

    always_comb begin
        node_next      = node_reg;
        used_next      = used_reg;
        missed_next    = missed_reg;
        ran_out_next   = ran_out_reg;
        act_next       = act_reg;
        last_next      = last_reg;
        addr_next      = addr_reg;
        clr_cnt_next   = clr_cnt_reg;
        res_next       = res_reg;
        m_valid_next   = m_valid_reg;
        m_payload_next = m_payload_reg;
        node_step      = node_reg;
        missed_step    = missed_reg;
        ran_step       = ran_out_reg;
        link_we        = 1'b0;
        link_wdata     = '0;
        mark_we        = 1'b0;

        if (cmd.clear_en) begin
            clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
            link_we      = 1'b1;
            mark_we      = (clr_cnt_reg < NODES_A);
        end

        if (accept) begin
            act_next  = s_payload.action;
            last_next = s_payload.last_symbol;
            addr_next = addr_calc;
        end

        if (cmd.step_en) begin
            if (act_reg == ACT_INSERT) begin
                if (!ran_out_reg) begin
                    if (link_ok) begin
                        node_step = link_rdata;
                    end else if (used_inc < NODES_V) begin
                        used_next  = used_inc[NODE_W-1:0];
                        link_we    = 1'b1;
                        link_wdata = used_inc[NODE_W-1:0];
                        node_step  = used_inc[NODE_W-1:0];
                    end else begin
                        ran_step = 1'b1;
                    end
                end
            end else if (!missed_reg) begin
                if (link_ok) begin
                    node_step = link_rdata;
                end else begin
                    missed_step = 1'b1;
                end
            end

            if (last_reg) begin
                node_next    = ROOT;
                ran_out_next = 1'b0;
                if (act_reg == ACT_INSERT) begin
                    missed_next = 1'b0;
                    mark_we     = ~ran_step;
                    res_next    = '{found: 1'b0, table_full: ran_step};
                end else begin
                    missed_next = missed_step;
                end
            end else begin
                node_next    = node_step;
                missed_next  = missed_step;
                ran_out_next = ran_step;
            end
        end

        if (cmd.mark_en) begin
            res_next    = '{found: ~missed_reg & mark_rdata, table_full: 1'b0};
            missed_next = 1'b0;
        end

        if (cmd.load_out) begin
            m_valid_next   = 1'b1;
            m_payload_next = res_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_reg    <= ROOT;
            used_reg    <= ROOT;
            missed_reg  <= 1'b0;
            ran_out_reg <= 1'b0;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            node_reg    <= node_next;
            used_reg    <= used_next;
            missed_reg  <= missed_next;
            ran_out_reg <= ran_out_next;
            clr_cnt_reg <= clr_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        act_reg       <= act_next;
        last_reg      <= last_next;
        addr_reg      <= addr_next;
        res_reg       <= res_next;
        m_payload_reg <= m_payload_next;
    end

    tril_ram #(
        .WIDTH (NODE_W),
        .DEPTH (TOTAL)
    ) u_link_ram (
        .aclk  (aclk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (addr_calc),
        .rdata (link_rdata)
    );

    tril_ram #(
        .WIDTH (1),
        .DEPTH (NODES)
    ) u_mark_ram (
        .aclk  (aclk),
        .we    (mark_we),
        .waddr (mark_waddr),
        .wdata (mark_wdata),
        .raddr (node_step),
        .rdata (mark_rdata)
    );

    assign s_ready   = cmd.accept_en;
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    assign sts.clear_done = (clr_cnt_reg == LAST_ADDR);
    assign sts.last       = last_reg;
    assign sts.lookup     = (act_reg == ACT_LOOKUP);
    assign sts.out_free   = ~m_valid_reg | m_ready;

endmodule

`default_nettype wire

// ===== hdl/tril_chk.sv =====
`default_nettype none

module tril_chk (
    input wire logic           aclk,
    input wire logic           aresetn,
    input wire logic           s_valid,
    input wire logic           s_ready,
    input wire tril_pkg::in_t  s_payload,
    input wire logic           m_valid,
    input wire logic           m_ready,
    input wire tril_pkg::out_t m_payload
);

    import tril_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("result changed while stalled");

    // found and table_full never both set (an insert never reports found, a lookup never full)
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_payload.found && m_payload.table_full))
        else $error("found and table_full both set");

    // clearing pass follows reset: nothing taken, nothing shown
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_ready && !m_valid)
        else $error("ready or valid straight after reset");

    // one symbol at a time
    a_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken in consecutive cycles");

endmodule

bind trie_insert_lookup_unit tril_chk u_chk (.*);

`default_nettype wire
